### rtl/nfsa_pkg.sv
package nfsa_pkg;

	localparam int unsigned SLOTS     = 8;
	localparam int unsigned MIN_SLOTS = 1;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned CNT_W     = 4;

	localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(SLOTS);
	localparam logic [CNT_W-1:0] MIN_LIMIT  = CNT_W'(MIN_SLOTS);

	typedef enum logic [2:0] {
		KIND_RESTART    = 3'd0,
		KIND_INSERT     = 3'd1,
		KIND_REMOVE_IDX = 3'd2,
		KIND_REMOVE_CUR = 3'd3,
		KIND_SELECT     = 3'd4,
		KIND_READ       = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PROBE,
		S_CHECK,
		S_OUT
	} state_t;

	typedef enum logic [0:0] {
		REG_ACTIVE_SLOTS = 1'b0
	} reg_idx_t;

endpackage

### rtl/next_fit_slot_allocator.sv
// Restart, remove, select, read and a refused insert go from execute straight to output;
// an insert probes k = 1..active_slots slots, each a read then a check, before output.
// One beat in flight: the next beat is taken only once the previous one has gone through
// execute, each probe (read, check) and output, which waits for a free result register.
// Reset (arst_n low): table empty, count and both pointers zero, active_slots = 8.
// No clearing pass: valid bits clear at reset; restart clears the active ones but slot 0.
module next_fit_slot_allocator (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // item_id[31:0], usage[39:32], slot_index[42:40], zero pad
	input  logic [2:0]  s_tuser,   // kind[2:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // result_slot[2:0], entry_id[34:3], entry_usage[42:35],
	                               // occupied_count[46:43], full_res[47]
	output logic [1:0]  m_tuser,   // status[1:0]
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned IW = nfsa_pkg::IDX_W;
	localparam int unsigned CW = nfsa_pkg::CNT_W;

	nfsa_pkg::state_t state_q, state_d;

	// latched input beat
	logic [2:0]    kind_q;
	logic [31:0]   id_q;
	logic [7:0]    use_q;
	logic [IW-1:0] idx_q;

	// allocator state
	logic [CW-1:0]               count_q;
	logic [IW-1:0]               cur_q;
	logic [IW-1:0]               ptr_q;
	logic [CW-1:0]               active_q;
	logic [nfsa_pkg::SLOTS-1:0]  vld_q;
	logic [1:0]                  status_q;

	// probe sequencer
	logic [CW-1:0] p_q;
	logic [CW-1:0] iter_q;
	logic [CW-1:0] p_eff;

	// slot table
	logic [31:0] mem_id  [nfsa_pkg::SLOTS];
	logic [7:0]  mem_use [nfsa_pkg::SLOTS];
	logic [31:0] rd_id_q;
	logic [7:0]  rd_use_q;
	logic        rd_vld_q;

	logic          rd_en;
	logic [IW-1:0] raddr;
	logic          mem_we;
	logic [IW-1:0] waddr;
	logic          probe_hit;
	logic          probe_last;
	logic          out_free;
	logic          in_beat;
	logic          cfg_we;
	logic [3:0]    cfg_val;
	logic [CW-1:0] cfg_clamped;
	logic [IW-1:0] rm_target;
	logic          idx_ok;
	logic          rm_ok;
	logic [nfsa_pkg::SLOTS-1:0] low_mask;
	logic [31:0]   res_id;
	logic [7:0]    res_use;

	assign in_beat    = s_tvalid && s_tready;
	assign out_free   = !m_tvalid || m_tready;
	assign p_eff      = (p_q >= active_q) ? '0 : p_q;
	assign probe_hit  = !rd_vld_q || (rd_id_q == 32'd0);
	assign probe_last = (iter_q == (active_q - CW'(1)));
	assign idx_ok     = ({1'b0, idx_q} < active_q);
	assign rm_target  = (kind_q == nfsa_pkg::KIND_REMOVE_IDX) ? idx_q : cur_q;
	assign rm_ok      = ({1'b0, rm_target} < active_q);

	always_comb begin
		for (int i = 0; i < nfsa_pkg::SLOTS; i++) begin
			low_mask[i] = (CW'(i) < active_q);
		end
	end

	// configuration
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite && pready
		&& (paddr[2] == nfsa_pkg::REG_ACTIVE_SLOTS);
	assign cfg_val = pwdata[3:0];
	always_comb begin
		if (cfg_val < nfsa_pkg::MIN_LIMIT) begin
			cfg_clamped = nfsa_pkg::MIN_LIMIT;
		end else if (cfg_val > nfsa_pkg::SLOT_LIMIT) begin
			cfg_clamped = nfsa_pkg::SLOT_LIMIT;
		end else begin
			cfg_clamped = cfg_val;
		end
	end
	assign prdata = (paddr[2] == nfsa_pkg::REG_ACTIVE_SLOTS) ? {28'd0, active_q} : 32'd0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			nfsa_pkg::S_IDLE: begin
				if (s_tvalid) state_d = nfsa_pkg::S_EXEC;
			end
			nfsa_pkg::S_EXEC: begin
				if (kind_q == nfsa_pkg::KIND_INSERT && count_q < active_q) begin
					state_d = nfsa_pkg::S_PROBE;
				end else begin
					state_d = nfsa_pkg::S_OUT;
				end
			end
			nfsa_pkg::S_PROBE: state_d = nfsa_pkg::S_CHECK;
			nfsa_pkg::S_CHECK: begin
				if (probe_hit || probe_last) state_d = nfsa_pkg::S_OUT;
				else state_d = nfsa_pkg::S_PROBE;
			end
			nfsa_pkg::S_OUT: begin
				if (out_free) state_d = nfsa_pkg::S_IDLE;
			end
			default: state_d = nfsa_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		raddr    = idx_q;
		mem_we   = 1'b0;
		waddr    = ptr_q;
		case (state_q)
			nfsa_pkg::S_IDLE: s_tready = 1'b1;
			nfsa_pkg::S_EXEC: begin
				rd_en = (kind_q == nfsa_pkg::KIND_READ);
				if (kind_q == nfsa_pkg::KIND_RESTART) begin
					mem_we = 1'b1;
					waddr  = '0;
				end
			end
			nfsa_pkg::S_PROBE: begin
				rd_en = 1'b1;
				raddr = p_eff[IW-1:0];
			end
			nfsa_pkg::S_CHECK: begin
				// empty slot found: write there; none left: overwrite at the insert pointer
				if (probe_hit) begin
					mem_we = 1'b1;
					waddr  = p_q[IW-1:0];
				end else if (probe_last) begin
					mem_we = 1'b1;
					waddr  = ptr_q;
				end
			end
			default: ;
		endcase
	end

	// slot table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_id[waddr]  <= id_q;
			mem_use[waddr] <= use_q;
		end
		if (rd_en) begin
			rd_id_q  <= mem_id[raddr];
			rd_use_q <= mem_use[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_q <= 1'b0;
		end else if (rd_en) begin
			rd_vld_q <= vld_q[raddr];
		end
	end

	// input latch
	always_ff @(posedge clk) begin
		if (in_beat) begin
			kind_q <= s_tuser;
			id_q   <= s_tdata[31:0];
			use_q  <= s_tdata[39:32];
			idx_q  <= s_tdata[42:40];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= nfsa_pkg::S_IDLE;
			count_q  <= '0;
			cur_q    <= '0;
			ptr_q    <= '0;
			active_q <= nfsa_pkg::SLOT_LIMIT;
			vld_q    <= '0;
			status_q <= nfsa_pkg::STAT_DONE;
			p_q      <= '0;
			iter_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) active_q <= cfg_clamped;
			case (state_q)
				nfsa_pkg::S_EXEC: begin
					status_q <= nfsa_pkg::STAT_DONE;
					case (kind_q)
						nfsa_pkg::KIND_RESTART: begin
							vld_q   <= (vld_q & ~low_mask) | nfsa_pkg::SLOTS'(1);
							count_q <= (id_q != 32'd0) ? CW'(1) : '0;
							cur_q   <= '0;
							ptr_q   <= '0;
						end
						nfsa_pkg::KIND_INSERT: begin
							if (count_q < active_q) begin
								count_q <= count_q + CW'(1);
								p_q     <= {1'b0, ptr_q} + CW'(1);
								iter_q  <= '0;
							end else begin
								status_q <= nfsa_pkg::STAT_FULL;
							end
						end
						nfsa_pkg::KIND_REMOVE_IDX, nfsa_pkg::KIND_REMOVE_CUR: begin
							if (!rm_ok) begin
								status_q <= nfsa_pkg::STAT_RANGE;
							end else if (count_q != '0) begin
								count_q          <= count_q - CW'(1);
								vld_q[rm_target] <= 1'b0;
							end
						end
						nfsa_pkg::KIND_SELECT: begin
							if (idx_ok) cur_q <= idx_q;
							else status_q <= nfsa_pkg::STAT_RANGE;
						end
						nfsa_pkg::KIND_READ: begin
							if (!idx_ok) status_q <= nfsa_pkg::STAT_RANGE;
						end
						default: ;
					endcase
				end
				nfsa_pkg::S_PROBE: begin
					p_q <= p_eff;
				end
				nfsa_pkg::S_CHECK: begin
					if (probe_hit) begin
						ptr_q <= p_q[IW-1:0];
						cur_q <= p_q[IW-1:0];
					end else if (probe_last) begin
						cur_q <= ptr_q;
					end else begin
						iter_q <= iter_q + CW'(1);
						p_q    <= p_q + CW'(1);
					end
					if (mem_we) vld_q[waddr] <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result register
	assign res_id  = (kind_q == nfsa_pkg::KIND_READ && status_q == nfsa_pkg::STAT_DONE
		&& rd_vld_q) ? rd_id_q : 32'd0;
	assign res_use = (kind_q == nfsa_pkg::KIND_READ && status_q == nfsa_pkg::STAT_DONE
		&& rd_vld_q) ? rd_use_q : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == nfsa_pkg::S_OUT && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == nfsa_pkg::S_OUT && out_free) begin
			m_tuser <= status_q;
			m_tdata <= {(count_q == active_q), count_q, res_use, res_id, cur_q};
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= nfsa_pkg::SLOT_LIMIT)
		else $error("occupied count above table size");

	a_active_range: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q >= nfsa_pkg::MIN_LIMIT) && (active_q <= nfsa_pkg::SLOT_LIMIT))
		else $error("slot limit outside clamp range");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nfsa_pkg::S_PROBE || state_q == nfsa_pkg::S_CHECK) |-> iter_q < active_q)
		else $error("probe ran past the slot limit");

	a_insert_current: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == nfsa_pkg::S_CHECK && mem_we) |=> (cur_q == ptr_q) && vld_q[cur_q])
		else $error("inserted slot not current or not marked valid");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> state_q == nfsa_pkg::S_EXEC && !s_tready)
		else $error("input beat not taken into execution");

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam logic [2:0] ACTIVE_SLOTS_ADDR = 3'(4 * int'(nfsa_pkg::REG_ACTIVE_SLOTS));
	localparam int STALL_LIMIT = 2000;
	localparam int IDLE_PCT = 18;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] id;
		logic [7:0]  usage;
		logic [2:0]  idx;
	} table_op_t;

	typedef struct packed {
		nfsa_pkg::status_t status;
		logic [2:0]  slot;
		logic [31:0] id;
		logic [7:0]  usage;
		logic [3:0]  count;
		logic        full;
	} table_resp_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	next_fit_slot_allocator u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// mirror of the slot table
	logic [31:0] slot_id_mirror [nfsa_pkg::SLOTS];
	logic [7:0]  slot_use_mirror [nfsa_pkg::SLOTS];
	logic [3:0]  held_count = '0;
	logic [3:0]  slot_limit = nfsa_pkg::SLOT_LIMIT;
	int          cur_slot = 0;
	int          ins_ptr = 0;

	table_op_t   cmd_fifo [$];
	table_resp_t owed_results [$];
	table_op_t   on_bus;
	table_resp_t want;
	bit          calm = 1'b0;
	int          mismatches = 0;
	int          stall_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < nfsa_pkg::SLOTS; i++) begin
			slot_id_mirror[i] = '0;
			slot_use_mirror[i] = '0;
		end
	end

	function automatic bit remove_slot(int slot);
		if (slot >= int'(slot_limit))
			return 1'b0;
		if (held_count != 0) begin
			held_count--;
			slot_id_mirror[slot] = '0;
			slot_use_mirror[slot] = '0;
		end
		return 1'b1;
	endfunction

	function automatic table_resp_t apply_table_op(table_op_t op);
		table_resp_t res;
		int probe;
		bit found;
		res = '0;
		res.status = nfsa_pkg::STAT_DONE;
		case (op.kind)
			nfsa_pkg::KIND_RESTART: begin
				// slots at or above the limit keep their contents
				for (int i = 0; i < int'(slot_limit); i++) begin
					slot_id_mirror[i] = '0;
					slot_use_mirror[i] = '0;
				end
				cur_slot = 0;
				ins_ptr = 0;
				held_count = (op.id == 0) ? 4'd0 : 4'd1;
				slot_id_mirror[0] = op.id;
				slot_use_mirror[0] = op.usage;
			end
			nfsa_pkg::KIND_INSERT: begin
				if (held_count < slot_limit) begin
					held_count++;
					probe = ins_ptr + 1;
					found = 1'b0;
					for (int i = 0; i < int'(slot_limit); i++) begin
						if (!found) begin
							if (probe >= int'(slot_limit))
								probe = 0;
							if (slot_id_mirror[probe] == 0) begin
								ins_ptr = probe;
								found = 1'b1;
							end else begin
								probe++;
							end
						end
					end
					// write the empty slot found, or with none, overwrite the one under the pointer
					slot_id_mirror[ins_ptr] = op.id;
					slot_use_mirror[ins_ptr] = op.usage;
					cur_slot = ins_ptr;
				end else begin
					res.status = nfsa_pkg::STAT_FULL;
				end
			end
			nfsa_pkg::KIND_REMOVE_IDX: begin
				if (!remove_slot(int'(op.idx))) res.status = nfsa_pkg::STAT_RANGE;
			end
			nfsa_pkg::KIND_REMOVE_CUR: begin
				if (!remove_slot(cur_slot)) res.status = nfsa_pkg::STAT_RANGE;
			end
			nfsa_pkg::KIND_SELECT: begin
				if (op.idx < slot_limit)
					cur_slot = int'(op.idx);
				else
					res.status = nfsa_pkg::STAT_RANGE;
			end
			nfsa_pkg::KIND_READ: begin
				if (op.idx < slot_limit) begin
					res.id = slot_id_mirror[op.idx];
					res.usage = slot_use_mirror[op.idx];
				end else begin
					res.status = nfsa_pkg::STAT_RANGE;
				end
			end
			default: ;
		endcase
		res.slot = 3'(cur_slot);
		res.count = held_count;
		res.full = (held_count == slot_limit);
		return res;
	endfunction

	function automatic table_op_t table_op(logic [2:0] kind, logic [31:0] id,
			logic [7:0] usage, logic [2:0] idx);
		table_op_t op;
		op.kind = kind;
		op.id = id;
		op.usage = usage;
		op.idx = idx;
		return op;
	endfunction

	function automatic table_op_t random_op();
		table_op_t op;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 5)       op.kind = nfsa_pkg::KIND_RESTART;
		else if (pick < 40) op.kind = nfsa_pkg::KIND_INSERT;
		else if (pick < 55) op.kind = nfsa_pkg::KIND_REMOVE_IDX;
		else if (pick < 65) op.kind = nfsa_pkg::KIND_REMOVE_CUR;
		else if (pick < 75) op.kind = nfsa_pkg::KIND_SELECT;
		else if (pick < 95) op.kind = nfsa_pkg::KIND_READ;
		else                op.kind = 3'($urandom_range(6, 7));
		pick = $urandom_range(0, 99);
		if (pick < 6)       op.id = '0;
		else if (pick < 10) op.id = '1;
		else                op.id = $urandom;
		op.usage = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 80)
			op.idx = 3'($urandom_range(0, int'(slot_limit) - 1));
		else
			op.idx = 3'($urandom_range(0, 7));
		return op;
	endfunction

	task automatic check_field(string name, logic [31:0] expv, logic [31:0] gotv);
		if (gotv !== expv) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t mismatch on %s: expected %h, got %h", $realtime, name, expv, gotv);
		end
	endtask

	// input driver: advance to the next command once the current beat is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready)
				owed_results.push_back(apply_table_op(on_bus));
			if (!s_tvalid || s_tready) begin
				if (cmd_fifo.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
					on_bus = cmd_fifo.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {5'b0, on_bus.idx, on_bus.usage, on_bus.id};
					s_tuser <= on_bus.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t result beat with nothing expected: %h/%h",
						$realtime, m_tuser, m_tdata);
			end else begin
				want = owed_results.pop_front();
				check_field("status", 32'(want.status), 32'(m_tuser));
				check_field("result_slot", 32'(want.slot), 32'(m_tdata[2:0]));
				check_field("entry_id", want.id, m_tdata[34:3]);
				check_field("entry_usage", 32'(want.usage), 32'(m_tdata[42:35]));
				check_field("occupied_count", 32'(want.count), 32'(m_tdata[46:43]));
				check_field("full_res", 32'(want.full), 32'(m_tdata[47]));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic apb_access(input bit is_write, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= is_write;
		paddr <= ACTIVE_SLOTS_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// sample away from the rising edge so the driver and monitor have settled
	task automatic wait_drained();
		do @(negedge clk);
		while (cmd_fifo.size() != 0 || s_tvalid || owed_results.size() != 0);
	endtask

	// write the slot limit with the table idle, then read it back
	task automatic set_slot_limit(logic [31:0] word);
		logic [31:0] rd;
		wait_drained();
		repeat (4) @(posedge clk);
		apb_access(1'b1, word, rd);
		if (word[3:0] < nfsa_pkg::MIN_LIMIT)
			slot_limit = nfsa_pkg::MIN_LIMIT;
		else if (word[3:0] > nfsa_pkg::SLOT_LIMIT)
			slot_limit = nfsa_pkg::SLOT_LIMIT;
		else
			slot_limit = word[3:0];
		apb_access(1'b0, '0, rd);
		check_field("active_slots", 32'(slot_limit), rd);
	endtask

	initial begin
		int limit_nibbles [12];
		limit_nibbles = '{8, 3, 5, 2, 15, 7, 1, 4, 12, 6, 0, 8};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		set_slot_limit({28'($urandom), 4'hF});
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_READ, 32'h0, 8'h00, 3'd0));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_RESTART, 32'hFFFF_FFFF, 8'hFF, 3'd7));
		for (int i = 1; i < 8; i++)
			cmd_fifo.push_back(table_op(nfsa_pkg::KIND_INSERT, 32'h1 << (i * 4),
				8'(i * 37), 3'(i)));
		// table full: refuse
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_INSERT, 32'hDEAD_BEEF, 8'h55, 3'd0));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_READ, 32'h0, 8'h00, 3'd7));
		// second remove of the same slot drops the count below the table
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_REMOVE_IDX, 32'h0, 8'h00, 3'd2));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_REMOVE_IDX, 32'h0, 8'h00, 3'd2));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_INSERT, 32'h8000_0000, 8'h80, 3'd0));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_INSERT, 32'h0000_0001, 8'h01, 3'd0));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_READ, 32'h0, 8'h00, 3'd2));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_SELECT, 32'h0, 8'h00, 3'd5));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_REMOVE_CUR, 32'h0, 8'h00, 3'd0));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_READ, 32'h0, 8'h00, 3'd5));
		cmd_fifo.push_back(table_op(3'd6, 32'hA5A5_A5A5, 8'hA5, 3'd1));
		cmd_fifo.push_back(table_op(3'd7, 32'h5A5A_5A5A, 8'h5A, 3'd6));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_RESTART, 32'h0, 8'h3C, 3'd0));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_REMOVE_IDX, 32'h0, 8'h00, 3'd3));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_SELECT, 32'h0, 8'h00, 3'd7));

		// limit drops below the current slot
		set_slot_limit({28'($urandom), 4'h0});
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_REMOVE_CUR, 32'h0, 8'h00, 3'd0));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_READ, 32'h0, 8'h00, 3'd7));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_SELECT, 32'h0, 8'h00, 3'd1));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_INSERT, 32'h1234_5678, 8'h9A, 3'd0));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_INSERT, 32'h8765_4321, 8'hBC, 3'd0));
		cmd_fifo.push_back(table_op(nfsa_pkg::KIND_RESTART, 32'h8000_0001, 8'h7E, 3'd0));

		for (int p = 0; p < 12; p++) begin
			set_slot_limit({28'($urandom), 4'(limit_nibbles[p])});
			calm = (p == 5);
			for (int n = 0; n < 100; n++)
				cmd_fifo.push_back(random_op());
		end

		wait_drained();
		calm = 1'b0;
		repeat (20) @(posedge clk);
		if (owed_results.size() != 0)
			mismatches++;
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
